/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// Implication: when the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared codes, widths and types of the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int MODE_W     = 2;
	localparam int KEY_PORT_W = 32;
	localparam int HOME_W     = 10;
	localparam int STATUS_W   = 2;
	localparam int LIMIT_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int COUNT_OUT_W = 10;
	localparam int MARK_W     = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd680;

	// Operation codes; the unused code behaves as a find.
	localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_PRESENT   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

	// Slot marks.
	localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
	localparam logic [MARK_W-1:0] MARK_ACTIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_CHECK
	} state_t;

endpackage

/* rtl/oaht_modadd.sv */
// ----------------------------------------------------------------------------
// oaht_modadd
// Shared modular adder: adds two slot values and folds once by the table size.
// ----------------------------------------------------------------------------
module oaht_modadd import oaht_pkg::*; #(
	parameter int TABLE_SIZE = 1021,
	parameter int PW = 11
) (
	input  logic [PW-1:0] a,
	input  logic [PW-1:0] b,
	output logic [PW-1:0] y
);

	localparam logic [PW:0] TS = (PW+1)'(TABLE_SIZE);

	logic [PW:0] sum;

	// The sum of the operands stays below twice the table size, so one fold is enough.
	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= TS) begin
			sum = sum - TS;
		end
		y = sum[PW-1:0];
	end

endmodule

/* rtl/oaht_ram.sv */
// ----------------------------------------------------------------------------
// oaht_ram
// Simple dual-port table memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module oaht_ram import oaht_pkg::*; #(
	parameter int DEPTH = 1021,
	parameter int AW = 10,
	parameter int DW = 34
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/open_address_hash_table_top.sv */
// ----------------------------------------------------------------------------
// open_address_hash_table_top
// Open-addressing key table with quadratic probing and lazy deletion.
// ----------------------------------------------------------------------------
// Usage:
// A command is a transfer on start while busy is low. It carries mode (find,
// insert or remove), key and home_index, the precomputed home slot of the key.
// The block then probes the table memory one slot at a time. Each probe
// first reduces or presents the address and then checks the registered
// read data. A home_index at or above the table size is first folded by
// the table size. The single shared modular adder and the one read port
// of the table memory allow one probe at a time, and busy keeps out a
// new command until the result.
// The result (status, slot, count) is shown for exactly one cycle with done
// high; the receiver cannot stall it. busy is low again in that cycle, so the
// next command may be given there.
// The load_limit register is written over its own channel (cfg_valid with
// cfg_ready, which is always high) and should only change while idle.
// After reset the block sweeps the table once to mark every slot empty,
// with busy high; load_limit resets to 680.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module open_address_hash_table_top import oaht_pkg::*; #(
	parameter int TABLE_SIZE = 1021,
	parameter int KEY_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Command channel.
	input  logic                   start,
	output logic                   busy,
	input  logic [MODE_W-1:0]      mode,
	input  logic [KEY_PORT_W-1:0]  key,
	input  logic [HOME_W-1:0]      home_index,
	// Configuration channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LIMIT_W-1:0]     load_limit,
	// Result channel.
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [HOME_W-1:0]      slot,
	output logic [COUNT_OUT_W-1:0] count
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	// The probe position also holds an unreduced home slot and a sum below
	// twice the table size, hence one bit above the wider of the two.
	localparam int PW = ((IDX_W > HOME_W) ? IDX_W : HOME_W) + 1;
	localparam int DW = MARK_W + KEY_WIDTH;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [PW-1:0] TS_P = PW'(TABLE_SIZE);

	state_t state_q, state_d;

	logic [KEY_WIDTH-1:0]   key_in;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [MODE_W-1:0]      mode_q;
	logic [PW-1:0]          p_q;
	logic [IDX_W-1:0]       step_q;
	logic [IDX_W-1:0]       clr_q;
	logic [COUNT_W-1:0]     cnt_q, cnt_d;
	logic [LIMIT_W-1:0]     limit_q;
	logic                   done_q;
	logic [STATUS_W-1:0]    status_q, status_d;
	logic [HOME_W-1:0]      slot_q;
	logic [COUNT_OUT_W-1:0] count_q;

	logic                   accept;
	logic                   fin;
	logic                   p_en;
	logic                   cnt_inc;
	logic [PW-1:0]          add_b, add_y;

	logic                   ram_we, ram_re;
	logic [IDX_W-1:0]       ram_waddr;
	logic [DW-1:0]          ram_wdata, ram_rdata;
	logic [MARK_W-1:0]      rd_mark;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic                   hit, active;

	// Keys are compared on KEY_WIDTH bits only.
	generate
		if (KEY_WIDTH <= KEY_PORT_W) begin : g_key_cut
			assign key_in = key[KEY_WIDTH-1:0];
		end else begin : g_key_ext
			assign key_in = {{(KEY_WIDTH - KEY_PORT_W){1'b0}}, key};
		end
	endgenerate

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign count     = count_q;

	assign rd_mark = ram_rdata[DW-1 -: MARK_W];
	assign rd_key  = ram_rdata[KEY_WIDTH-1:0];
	assign hit     = (rd_mark == MARK_EMPTY) || (rd_key == key_q);
	assign active  = (rd_mark == MARK_ACTIVE);

	// The adder folds the home slot while probing has not begun, and adds the
	// growing probe offset after each miss.
	assign add_b = (state_q == S_CHECK) ? (PW'(step_q) + PW'(1)) : '0;

	oaht_modadd #(
		.TABLE_SIZE(TABLE_SIZE),
		.PW(PW)
	) u_add (
		.a(p_q),
		.b(add_b),
		.y(add_y)
	);

	oaht_ram #(
		.DEPTH(TABLE_SIZE),
		.AW(IDX_W),
		.DW(DW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(p_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory control and the result decision.
	always_comb begin
		state_d   = state_q;
		fin       = 1'b0;
		p_en      = 1'b0;
		cnt_inc   = 1'b0;
		status_d  = STAT_DONE;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = p_q[IDX_W-1:0];
		ram_wdata = {MARK_ACTIVE, key_q};
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = {MARK_EMPTY, {KEY_WIDTH{1'b0}}};
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (p_q >= TS_P) begin
					p_en = 1'b1;
				end else begin
					ram_re  = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (hit) begin
					fin = 1'b1;
					case (mode_q)
						MODE_INSERT: begin
							if (active) begin
								status_d = STAT_PRESENT;
							end else if (cnt_q >= {1'b0, limit_q}) begin
								status_d = STAT_FULL;
							end else begin
								ram_we   = 1'b1;
								cnt_inc  = 1'b1;
								status_d = STAT_DONE;
							end
						end
						MODE_REMOVE: begin
							if (active) begin
								ram_we    = 1'b1;
								ram_wdata = {MARK_DELETED, key_q};
								status_d  = STAT_DONE;
							end else begin
								status_d = STAT_NOT_FOUND;
							end
						end
						default: begin
							status_d = active ? STAT_DONE : STAT_NOT_FOUND;
						end
					endcase
				end else if (step_q == LAST_IDX) begin
					// As many probes as the table has slots were made without a stop.
					fin      = 1'b1;
					status_d = STAT_FULL;
				end else begin
					p_en    = 1'b1;
					state_d = S_PROBE;
				end
				if (fin) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cnt_d = cnt_inc ? (cnt_q + COUNT_W'(1)) : cnt_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			step_q  <= '0;
			cnt_q   <= '0;
			limit_q <= LIMIT_RESET;
			done_q  <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (accept) begin
				step_q <= '0;
			end else if (p_en && (state_q == S_CHECK)) begin
				step_q <= step_q + IDX_W'(1);
			end
			cnt_q <= cnt_d;
			if (cfg_valid) begin
				limit_q <= load_limit;
			end
			done_q <= fin;
		end
	end

	// Command and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_in;
			mode_q <= mode;
			p_q    <= PW'(home_index);
		end else if (p_en) begin
			p_q <= add_y;
		end
		if (fin) begin
			status_q <= status_d;
			slot_q   <= p_q[HOME_W-1:0];
			count_q  <= cnt_d[COUNT_OUT_W-1:0];
		end
	end

	// The table is written only by the clearing sweep or a finishing command.
	`ASSERT_IMPLY(a_wr_state, clk, arst_n, ram_we, (state_q == S_CLEAR) || (fin && (state_q == S_CHECK)))
	// A table read always addresses a reduced slot.
	`ASSERT_IMPLY(a_rd_range, clk, arst_n, ram_re, p_q < TS_P)
	// A result follows a check cycle and leaves the block idle.
	`ASSERT_IMPLY(a_done_src, clk, arst_n, done_q, ($past(state_q) == S_CHECK) && (state_q == S_IDLE))
	// The insert count only ever moves up by one.
	`ASSERT_IMPLY(a_cnt_step, clk, arst_n, cnt_q != $past(cnt_q), cnt_q == ($past(cnt_q) + COUNT_W'(1)))

endmodule

/* tb/sv/oaht_tb_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_tb_pkg
// Scoreboard of the open-addressing hash table testbench. It keeps its own
// copy of the table and predicts the outcome of every accepted command.
// ----------------------------------------------------------------------------
package oaht_tb_pkg;
	import oaht_pkg::*;

	localparam int TBL = 1021;

	// The fourth operation code has no name in the design package; it acts as a find.
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [HOME_W-1:0]      slot;
		logic [COUNT_OUT_W-1:0] count;
	} table_outcome_t;

	class hash_table_scoreboard;
		table_outcome_t     outcome_q[$];
		logic [31:0]        key_store[TBL];
		logic [MARK_W-1:0]  mark_store[TBL];
		logic [COUNT_W-1:0] insert_total;
		logic [LIMIT_W-1:0] limit_reg;
		int unsigned        fail_count;

		function new();
			for (int i = 0; i < TBL; i++) begin
				key_store[i] = '0;
				mark_store[i] = MARK_EMPTY;
			end
			insert_total = '0;
			limit_reg = LIMIT_RESET;
			fail_count = 0;
		endfunction

		// Walks the triangular probe sequence; returns 0 when no slot stopped it.
		function bit probe_table(input logic [31:0] k, input logic [HOME_W-1:0] h,
				output int unsigned pos);
			int unsigned p;
			p = h % TBL;
			pos = p;
			for (int unsigned n = 0; n < TBL; n++) begin
				pos = p;
				if (mark_store[p] == MARK_EMPTY || key_store[p] == k)
					return 1'b1;
				p = (p + n + 1) % TBL;
			end
			return 1'b0;
		endfunction

		function void note_command(input logic [MODE_W-1:0] op, input logic [31:0] k,
				input logic [HOME_W-1:0] h);
			table_outcome_t r;
			int unsigned pos;
			bit hit;
			bit active;
			hit = probe_table(k, h, pos);
			r.slot = pos[HOME_W-1:0];
			if (!hit) begin
				r.status = STAT_FULL;
			end else begin
				active = mark_store[pos] == MARK_ACTIVE;
				case (op)
					MODE_INSERT: begin
						if (active) begin
							r.status = STAT_PRESENT;
						end else if (insert_total >= limit_reg) begin
							r.status = STAT_FULL;
						end else begin
							key_store[pos] = k;
							mark_store[pos] = MARK_ACTIVE;
							insert_total = insert_total + 1'b1;
							r.status = STAT_DONE;
						end
					end
					MODE_REMOVE: begin
						if (active) begin
							mark_store[pos] = MARK_DELETED;
							r.status = STAT_DONE;
						end else begin
							r.status = STAT_NOT_FOUND;
						end
					end
					default: r.status = active ? STAT_DONE : STAT_NOT_FOUND;
				endcase
			end
			r.count = insert_total[COUNT_OUT_W-1:0];
			outcome_q.push_back(r);
		endfunction

		function void log_mismatch(input string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_outcome(input logic [STATUS_W-1:0] st,
				input logic [HOME_W-1:0] sl, input logic [COUNT_OUT_W-1:0] cnt);
			table_outcome_t e;
			if (outcome_q.size() == 0) begin
				log_mismatch($sformatf("result with nothing pending: status %0d slot %0d count %0d",
					st, sl, cnt));
				return;
			end
			e = outcome_q.pop_front();
			if (st !== e.status || sl !== e.slot || cnt !== e.count)
				log_mismatch($sformatf("expected status %0d slot %0d count %0d, got status %0d slot %0d count %0d",
					e.status, e.slot, e.count, st, sl, cnt));
		endfunction
	endclass

endpackage

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the open-addressing hash table. Commands are sent through the
// start/busy handshake and every result strobe is checked against a scoreboard
// that mirrors the table, across several load limits and a saturated probe path.
// ----------------------------------------------------------------------------
module tb_top import oaht_pkg::*, oaht_tb_pkg::*;;

	localparam int          POOL_SIZE     = 96;
	localparam int          LIMIT_CYCLES  = 8000000;
	localparam int          END_SLACK     = 16;
	localparam logic [31:0] PROBE_KEY     = 32'h5EED_1234;
	localparam logic [31:0] FILL_KEY_BASE = 32'hC0DE_0000;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [MODE_W-1:0]      mode;
	logic [KEY_PORT_W-1:0]  key;
	logic [HOME_W-1:0]      home_index;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [LIMIT_W-1:0]     load_limit;
	logic                   done;
	logic [STATUS_W-1:0]    status;
	logic [HOME_W-1:0]      slot;
	logic [COUNT_OUT_W-1:0] count;

	hash_table_scoreboard table_sb;

	// Keys of the random part, each with a fixed home slot, so that a key is
	// always looked up where it was inserted, as a real hash would do.
	logic [31:0]       pool_key[POOL_SIZE];
	logic [HOME_W-1:0] pool_home[POOL_SIZE];

	// Chance in percent that the sender leaves a gap before a command.
	int idle_pct;
	int unsigned cycle_count;

	open_address_hash_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.key(key),
		.home_index(home_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.load_limit(load_limit),
		.done(done),
		.status(status),
		.slot(slot),
		.count(count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results cannot be held off, so every strobe is checked at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && done)
			table_sb.check_outcome(status, slot, count);
	end

	// Watchdog: the slowest legal run walks the whole probe sequence for every
	// command, which stays far below this bound.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// One command transfer. start stays high after the transfer so that the
	// next command can follow back to back; a gap keeps it low past the point
	// at which the block could already take a command.
	task automatic send_command(input logic [MODE_W-1:0] op, input logic [31:0] k,
			input logic [HOME_W-1:0] h);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= op;
		key <= k;
		home_index <= h;
		do @(posedge clk); while (busy);
		table_sb.note_command(op, k, h);
	endtask

	// Lowers start and waits until every pending result has been checked.
	task automatic drain_results();
		start <= 1'b0;
		while (table_sb.outcome_q.size() != 0) @(posedge clk);
	endtask

	// Register writes happen only while the table is idle.
	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		cfg_valid <= 1'b1;
		load_limit <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		table_sb.limit_reg = v;
	endtask

	// Mostly pool keys at their own homes, with some noise commands that use
	// fresh keys, any home slot and any operation code.
	task automatic run_random(input int n);
		logic [MODE_W-1:0] op;
		logic [31:0]       k;
		logic [HOME_W-1:0] h;
		int                pick;
		int                w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				op = MODE_W'($urandom_range(3));
				k = $urandom;
				if (k == PROBE_KEY)
					k[0] = ~k[0];
				h = HOME_W'($urandom_range(1023));
			end else begin
				pick = $urandom_range(POOL_SIZE - 1);
				k = pool_key[pick];
				h = pool_home[pick];
				w = $urandom_range(99);
				if (w < 40)
					op = MODE_INSERT;
				else if (w < 70)
					op = MODE_FIND;
				else if (w < 93)
					op = MODE_REMOVE;
				else
					op = MODE_SPARE;
			end
			send_command(op, k, h);
		end
	endtask

	initial begin
		logic [HOME_W-1:0] cluster[8];
		bit                seen[TBL];
		int unsigned       path_free[$];
		int unsigned       p;

		table_sb = new();
		idle_pct = 26;
		arst_n <= 1'b0;
		start <= 1'b0;
		mode <= MODE_FIND;
		key <= '0;
		home_index <= '0;
		cfg_valid <= 1'b0;
		load_limit <= LIMIT_RESET;

		// Homes gather around a few slots so that probe chains form; three of them
		// are at or above the table size and fold back to its start.
		cluster[0] = 10'd0;
		cluster[1] = 10'd1020;
		cluster[2] = 10'd1021;
		cluster[3] = 10'd1022;
		cluster[4] = 10'd1023;
		for (int i = 5; i < 8; i++)
			cluster[i] = HOME_W'($urandom_range(1020));
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_key[i] = $urandom;
			if (pool_key[i] == PROBE_KEY)
				pool_key[i][0] = ~pool_key[i][0];
			pool_home[i] = ($urandom_range(99) < 60) ? cluster[$urandom_range(7)]
				: 10'($urandom_range(1023));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset load limit. The first command waits out
		// the clearing sweep through the handshake.
		send_command(MODE_INSERT, 32'h0000_0000, 10'd0);
		send_command(MODE_INSERT, 32'hFFFF_FFFF, 10'd0);
		send_command(MODE_INSERT, 32'hFFFF_FFFF, 10'd0);   // already present
		send_command(MODE_FIND,   32'hFFFF_FFFF, 10'd0);
		send_command(MODE_SPARE,  32'h0000_0000, 10'd0);   // spare code is a find
		send_command(MODE_FIND,   32'h1234_5678, 10'd0);   // absent key
		send_command(MODE_REMOVE, 32'h0000_0000, 10'd0);
		// The deleted slot still holds the key, so the probe stops there.
		send_command(MODE_FIND,   32'h0000_0000, 10'd0);
		send_command(MODE_REMOVE, 32'h0000_0000, 10'd0);
		// A deleted slot with another key does not stop the probe.
		send_command(MODE_FIND,   32'hFFFF_FFFF, 10'd0);
		send_command(MODE_INSERT, 32'h0000_0000, 10'd0);   // reuses the deleted slot
		// Home slots above the table size fold back by the table size.
		send_command(MODE_INSERT, 32'hAAAA_AAAA, 10'd1023);
		send_command(MODE_FIND,   32'hAAAA_AAAA, 10'd2);
		send_command(MODE_INSERT, 32'h5555_5555, 10'd1021);
		send_command(MODE_FIND,   32'h5555_5555, 10'd0);
		send_command(MODE_INSERT, 32'h8765_4321, 10'd1020);
		send_command(MODE_REMOVE, 32'h8765_4321, 10'd1020);
		send_command(MODE_INSERT, 32'h1357_9BDF, 10'h2AA);
		send_command(MODE_SPARE,  32'h2468_ACE0, 10'h155);
		send_command(MODE_REMOVE, 32'hAAAA_AAAA, 10'd1022);
		send_command(MODE_FIND,   32'hAAAA_AAAA, 10'd1023);
		send_command(MODE_REMOVE, 32'hFFFF_FFFF, 10'd1021);

		// A zero limit refuses every new key, yet a present key still reports present.
		drain_results();
		write_limit(10'd0);
		send_command(MODE_INSERT, 32'hDEAD_BEEF, 10'd5);
		send_command(MODE_INSERT, 32'h0000_0000, 10'd0);
		run_random(30);

		// A limit just above the current count is reached within this phase.
		drain_results();
		write_limit(table_sb.insert_total[LIMIT_W-1:0] + 10'd8);
		run_random(80);

		// Largest limit; the first stretch runs with no sender gaps at all.
		drain_results();
		write_limit(10'h3FF);
		idle_pct = 0;
		run_random(70);
		idle_pct = 26;
		run_random(90);

		// Fill every free slot on the probe path of home slot zero, each key at
		// its own home so that it lands there in one probe. After that a key
		// held nowhere on the path runs into the probe limit.
		drain_results();
		for (int i = 0; i < TBL; i++)
			seen[i] = 1'b0;
		p = 0;
		for (int unsigned n = 0; n < TBL; n++) begin
			if (!seen[p] && table_sb.mark_store[p] == MARK_EMPTY)
				path_free.push_back(p);
			seen[p] = 1'b1;
			p = (p + n + 1) % TBL;
		end
		foreach (path_free[i])
			send_command(MODE_INSERT, FILL_KEY_BASE + 32'(i), 10'(path_free[i]));
		drain_results();
		send_command(MODE_FIND,   PROBE_KEY, 10'd0);
		send_command(MODE_INSERT, PROBE_KEY, 10'd0);
		send_command(MODE_REMOVE, PROBE_KEY, 10'd0);
		send_command(MODE_SPARE,  PROBE_KEY, 10'd0);
		send_command(MODE_FIND,   PROBE_KEY, 10'd1021);

		// Smallest nonzero limit on a crowded table.
		drain_results();
		write_limit(10'd1);
		run_random(40);

		drain_results();
		repeat (END_SLACK) @(posedge clk);
		if (table_sb.fail_count == 0 && table_sb.outcome_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* open_address_hash_table_top.f */
+incdir+rtl
rtl/oaht_pkg.sv
rtl/oaht_modadd.sv
rtl/oaht_ram.sv
rtl/open_address_hash_table_top.sv
tb/sv/oaht_tb_pkg.sv
tb/sv/tb_top.sv
